// ===== rtl/pose_kalman_filter_six_channel_macros.svh =====
// assertion macros used by the checker module pkf_chk
`ifndef POSE_KALMAN_FILTER_SIX_CHANNEL_MACROS_SVH
`define POSE_KALMAN_FILTER_SIX_CHANNEL_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PKF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkf assertion failed");

// next-cycle implication, disabled while in reset
`define PKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkf assertion failed");

`endif

// ===== rtl/pkf_pkg.sv =====
package pkf_pkg;

    // sizes
    localparam int CHANNELS_DEF = 6;
    localparam int CH_MAX       = 6;
    localparam int CH_W         = 3;
    localparam int DW           = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int K_W          = 17;
    localparam int PROD_W       = DW + 1 + K_W;
    localparam int DIV_STEPS    = 17;
    localparam int DIV_CNT_W    = 5;

    // fixed point constants, unsigned q16.16
    localparam logic [K_W-1:0] ONE_Q16       = 17'd65536;
    localparam logic [DW-1:0]  VAR_RST       = 32'd65536;
    localparam logic [DW-1:0]  Q_FIRST_RST   = 32'd6554;
    localparam logic [DW-1:0]  Q_REST_RST    = 32'd655;
    localparam logic [DW-1:0]  R_FIRST_RST   = 32'd13107;
    localparam logic [DW-1:0]  R_REST_RST    = 32'd655;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q_FIRST,
        CFG_Q_REST,
        CFG_R_FIRST,
        CFG_R_REST
    } cfg_reg_t;

    // request payload
    typedef struct packed {
        logic signed [DW-1:0] meas_x;
        logic signed [DW-1:0] meas_y;
        logic signed [DW-1:0] meas_z;
        logic signed [DW-1:0] meas_roll;
        logic signed [DW-1:0] meas_pitch;
        logic signed [DW-1:0] meas_yaw;
        logic                 meas_bad;
    } meas_t;

    // result payload
    typedef struct packed {
        logic signed [DW-1:0] est_x;
        logic signed [DW-1:0] est_y;
        logic signed [DW-1:0] est_z;
        logic signed [DW-1:0] est_roll;
        logic signed [DW-1:0] est_pitch;
        logic signed [DW-1:0] est_yaw;
        logic [DW-1:0]        var_first_out;
        logic [DW-1:0]        var_rest_out;
        logic                 skipped;
    } est_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_PRED,
        OP_DIV0,
        OP_CAPK0,
        OP_DIV1,
        OP_CAPK1,
        OP_MULC,
        OP_ADDC,
        OP_MULV0,
        OP_WRV0,
        OP_MULV1,
        OP_WRV1,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [CH_W-1:0] ch;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/pkf_div.sv =====
// restoring divider for the gain: quot = floor(pp * 2^16 / den), one bit per cycle
// the quotient never exceeds 2^16, so only the low 17 quotient bits are formed
module pkf_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [pkf_pkg::DW-1:0]   pp,
    input  logic [pkf_pkg::DW:0]     den,
    output logic                     done,
    output logic [pkf_pkg::K_W-1:0]  quot
);

    logic [pkf_pkg::DW:0]          rem_reg;
    logic [pkf_pkg::DW:0]          den_reg;
    logic [pkf_pkg::K_W-1:0]       bits_reg;
    logic [pkf_pkg::K_W-1:0]       quot_reg;
    logic [pkf_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [pkf_pkg::DW+1:0]        trial;
    logic [pkf_pkg::DW+1:0]        diff;
    logic                          fits;

    // trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, bits_reg[pkf_pkg::K_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // iteration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            bits_reg <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            // upper dividend bits give no quotient bits, preload them as remainder
            rem_reg  <= {2'b00, pp[pkf_pkg::DW-1:1]};
            // divisor held for the whole divide
            den_reg  <= den;
            bits_reg <= {pp[0], {(pkf_pkg::K_W-1){1'b0}}};
            quot_reg <= '0;
            cnt_reg  <= pkf_pkg::DIV_CNT_W'(pkf_pkg::DIV_STEPS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[pkf_pkg::DW:0] : trial[pkf_pkg::DW:0];
            bits_reg <= bits_reg << 1;
            quot_reg <= {quot_reg[pkf_pkg::K_W-2:0], fits};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == pkf_pkg::DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/pkf_dp.sv =====
// filter datapath: configuration, state, shared divider and multiplier, result register
module pkf_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pkf_pkg::dp_cmd_t               cmd,
    output pkf_pkg::dp_stat_t              stat,
    input  pkf_pkg::meas_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pkf_pkg::est_t                  out_data,
    input  logic                           cfg_wr_en,
    input  logic [pkf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pkf_pkg::DW-1:0]         cfg_data
);

    localparam int DW  = pkf_pkg::DW;
    localparam int KW  = pkf_pkg::K_W;
    localparam int PW  = pkf_pkg::PROD_W;

    logic [DW-1:0]        q_first_reg;
    logic [DW-1:0]        q_rest_reg;
    logic [DW-1:0]        r_first_reg;
    logic [DW-1:0]        r_rest_reg;
    logic signed [DW-1:0] est_reg [pkf_pkg::CH_MAX];
    logic [DW-1:0]        var_first_reg;
    logic [DW-1:0]        var_rest_reg;
    pkf_pkg::meas_t       in_reg;
    logic [DW-1:0]        pp0_reg;
    logic [DW-1:0]        pp1_reg;
    logic [KW-1:0]        k0_reg;
    logic [KW-1:0]        k1_reg;
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;
    logic                 out_valid_reg;
    pkf_pkg::est_t        out_reg;

    logic signed [DW-1:0] z_arr [pkf_pkg::CH_MAX];
    logic [DW:0]          pp0_sum;
    logic [DW:0]          pp1_sum;
    logic                 div_start;
    logic [DW-1:0]        div_pp;
    logic [DW:0]          div_den;
    logic                 div_done;
    logic [KW-1:0]        div_quot;
    logic signed [DW-1:0] x_cur;
    logic signed [DW:0]   resid;
    logic                 resid_neg;
    logic [DW:0]          resid_mag;
    logic [DW:0]          mul_a;
    logic [KW-1:0]        mul_b;
    logic [DW:0]          corr;
    logic signed [DW+1:0] upd;
    logic signed [DW-1:0] est_new;

    // measurement channels in index order
    always_comb
    begin
        z_arr[0] = in_reg.meas_x;
        z_arr[1] = in_reg.meas_y;
        z_arr[2] = in_reg.meas_z;
        z_arr[3] = in_reg.meas_roll;
        z_arr[4] = in_reg.meas_pitch;
        z_arr[5] = in_reg.meas_yaw;
    end

    // predicted variances, saturating
    assign pp0_sum = {1'b0, var_first_reg} + {1'b0, q_first_reg};
    assign pp1_sum = {1'b0, var_rest_reg} + {1'b0, q_rest_reg};

    // divider operands: innovation variance pp + r in 33 bits
    assign div_start = (cmd.op == pkf_pkg::OP_DIV0) || (cmd.op == pkf_pkg::OP_DIV1);
    assign div_pp    = (cmd.op == pkf_pkg::OP_DIV1) ? pp1_reg : pp0_reg;
    assign div_den   = (cmd.op == pkf_pkg::OP_DIV1) ? ({1'b0, pp1_reg} + {1'b0, r_rest_reg})
                                                    : ({1'b0, pp0_reg} + {1'b0, r_first_reg});

    pkf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .pp    (div_pp),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // residual of the current channel
    always_comb
    begin
        x_cur     = est_reg[cmd.ch];
        resid     = {z_arr[cmd.ch][DW-1], z_arr[cmd.ch]} - {x_cur[DW-1], x_cur};
        resid_neg = resid[DW];
        resid_mag = resid_neg ? (~resid + 1'b1) : resid;
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.op)
            pkf_pkg::OP_MULV0:
            begin
                mul_a = {1'b0, pp0_reg};
                mul_b = pkf_pkg::ONE_Q16 - k0_reg;
            end
            pkf_pkg::OP_MULV1:
            begin
                mul_a = {1'b0, pp1_reg};
                mul_b = pkf_pkg::ONE_Q16 - k1_reg;
            end
            default:
            begin
                mul_a = resid_mag;
                mul_b = (cmd.ch == '0) ? k0_reg : k1_reg;
            end
        endcase
    end

    // corrected estimate, saturated to 32 bits
    always_comb
    begin
        corr = prod_reg[DW+16:16];
        if (neg_reg)
            upd = {{2{x_cur[DW-1]}}, x_cur} - $signed({1'b0, corr});
        else
            upd = {{2{x_cur[DW-1]}}, x_cur} + $signed({1'b0, corr});
        if (upd[DW+1:DW-1] == 3'b000 || upd[DW+1:DW-1] == 3'b111)
            est_new = upd[DW-1:0];
        else if (upd[DW+1])
            est_new = {1'b1, {(DW-1){1'b0}}};
        else
            est_new = {1'b0, {(DW-1){1'b1}}};
    end

    // configuration, filter state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_first_reg   <= pkf_pkg::Q_FIRST_RST;
            q_rest_reg    <= pkf_pkg::Q_REST_RST;
            r_first_reg   <= pkf_pkg::R_FIRST_RST;
            r_rest_reg    <= pkf_pkg::R_REST_RST;
            for (int i = 0; i < pkf_pkg::CH_MAX; i++)
            begin
                est_reg[i] <= '0;
            end
            var_first_reg <= pkf_pkg::VAR_RST;
            var_rest_reg  <= pkf_pkg::VAR_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (pkf_pkg::cfg_reg_t'(cfg_index))
                    pkf_pkg::CFG_Q_FIRST: q_first_reg <= cfg_data;
                    pkf_pkg::CFG_Q_REST:  q_rest_reg  <= cfg_data;
                    pkf_pkg::CFG_R_FIRST: r_first_reg <= cfg_data;
                    pkf_pkg::CFG_R_REST:  r_rest_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == pkf_pkg::OP_ADDC)
                est_reg[cmd.ch] <= est_new;
            if (cmd.op == pkf_pkg::OP_WRV0)
                var_first_reg <= prod_reg[DW+15:16];
            if (cmd.op == pkf_pkg::OP_WRV1)
                var_rest_reg <= prod_reg[DW+15:16];
            if (cmd.op == pkf_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pkf_pkg::OP_TAKE:
            begin
                in_reg <= in_data;
            end
            pkf_pkg::OP_PRED:
            begin
                pp0_reg <= pp0_sum[DW] ? '1 : pp0_sum[DW-1:0];
                pp1_reg <= pp1_sum[DW] ? '1 : pp1_sum[DW-1:0];
            end
            pkf_pkg::OP_CAPK0:
            begin
                if (div_done)
                    k0_reg <= (pp0_reg == '0 && r_first_reg == '0) ? '0 : div_quot;
            end
            pkf_pkg::OP_CAPK1:
            begin
                if (div_done)
                    k1_reg <= (pp1_reg == '0 && r_rest_reg == '0) ? '0 : div_quot;
            end
            pkf_pkg::OP_MULC, pkf_pkg::OP_MULV0, pkf_pkg::OP_MULV1:
            begin
                prod_reg <= PW'(mul_a * mul_b);
                neg_reg  <= resid_neg;
            end
            pkf_pkg::OP_OUT:
            begin
                out_reg.est_x         <= est_reg[0];
                out_reg.est_y         <= est_reg[1];
                out_reg.est_z         <= est_reg[2];
                out_reg.est_roll      <= est_reg[3];
                out_reg.est_pitch     <= est_reg[4];
                out_reg.est_yaw       <= est_reg[5];
                out_reg.var_first_out <= var_first_reg;
                out_reg.var_rest_out  <= var_rest_reg;
                out_reg.skipped       <= in_reg.meas_bad;
            end
            default: ;
        endcase
    end

    assign stat.bad      = in_reg.meas_bad;
    assign stat.div_done = div_done;
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

endmodule

// ===== rtl/pkf_ctrl.sv =====
// sequencer: bad check, predict, two gain divides, per-channel correction, variance update, result load
module pkf_ctrl #(
    parameter int CHANNELS = pkf_pkg::CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pkf_pkg::dp_stat_t  stat,
    output pkf_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PRED,
        S_DIV0,
        S_WAIT0,
        S_DIV1,
        S_WAIT1,
        S_MULC,
        S_ADDC,
        S_MULV0,
        S_WRV0,
        S_MULV1,
        S_WRV1,
        S_DONE
    } state_t;

    localparam logic [pkf_pkg::CH_W-1:0] CH_LAST = pkf_pkg::CH_W'(CHANNELS - 1);

    state_t                  state_reg;
    logic [pkf_pkg::CH_W-1:0] ch_reg;

    // state and channel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    state_reg <= stat.bad ? S_DONE : S_PRED;
                end
                S_PRED:
                begin
                    state_reg <= S_DIV0;
                end
                S_DIV0:
                begin
                    state_reg <= S_WAIT0;
                end
                S_WAIT0:
                begin
                    if (stat.div_done)
                        state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    state_reg <= S_WAIT1;
                end
                S_WAIT1:
                begin
                    if (stat.div_done)
                    begin
                        ch_reg    <= '0;
                        state_reg <= S_MULC;
                    end
                end
                S_MULC:
                begin
                    state_reg <= S_ADDC;
                end
                S_ADDC:
                begin
                    if (ch_reg == CH_LAST)
                        state_reg <= S_MULV0;
                    else
                    begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= S_MULC;
                    end
                end
                S_MULV0:
                begin
                    state_reg <= S_WRV0;
                end
                S_WRV0:
                begin
                    // a single channel leaves the shared variance alone
                    state_reg <= (CHANNELS > 1) ? S_MULV1 : S_DONE;
                end
                S_MULV1:
                begin
                    state_reg <= S_WRV1;
                end
                S_WRV1:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!stat.out_busy)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath command decode
    always_comb
    begin
        cmd.ch = ch_reg;
        case (state_reg)
            S_IDLE:  cmd.op = in_valid ? pkf_pkg::OP_TAKE : pkf_pkg::OP_NONE;
            S_PRED:  cmd.op = pkf_pkg::OP_PRED;
            S_DIV0:  cmd.op = pkf_pkg::OP_DIV0;
            S_WAIT0: cmd.op = pkf_pkg::OP_CAPK0;
            S_DIV1:  cmd.op = pkf_pkg::OP_DIV1;
            S_WAIT1: cmd.op = pkf_pkg::OP_CAPK1;
            S_MULC:  cmd.op = pkf_pkg::OP_MULC;
            S_ADDC:  cmd.op = pkf_pkg::OP_ADDC;
            S_MULV0: cmd.op = pkf_pkg::OP_MULV0;
            S_WRV0:  cmd.op = pkf_pkg::OP_WRV0;
            S_MULV1: cmd.op = pkf_pkg::OP_MULV1;
            S_WRV1:  cmd.op = pkf_pkg::OP_WRV1;
            S_DONE:  cmd.op = stat.out_busy ? pkf_pkg::OP_NONE : pkf_pkg::OP_OUT;
            default: cmd.op = pkf_pkg::OP_NONE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== rtl/pose_kalman_filter_six_channel.sv =====
// Six-channel pose Kalman filter with identity models and diagonal covariance, signed
// Q16.16 in and out. One request is worked on at a time: a good measurement is
// predicted, gets its two gains from 17-step divides on the shared restoring divider,
// is corrected channel by channel and updates the variances (the rest variance only
// when CHANNELS is above 1) before the result is loaded; a request flagged bad skips
// straight to the load and returns the held state with skipped set. The result sits
// in an output register, so the next request is taken while it waits. Configuration
// writes take effect at once and belong only to times when no request is in flight.
module pose_kalman_filter_six_channel #(
    parameter int CHANNELS = pkf_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pkf_pkg::meas_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pkf_pkg::est_t                  out_data,
    input  logic                           cfg_wr_en,
    input  logic [pkf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pkf_pkg::DW-1:0]         cfg_data
);

    pkf_pkg::dp_cmd_t  cmd;
    pkf_pkg::dp_stat_t stat;

    // sequencer
    pkf_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and state
    pkf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== rtl/pkf_chk.sv =====
`include "pose_kalman_filter_six_channel_macros.svh"

// port-level checks on the filter
module pkf_chk (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic          out_valid,
    input  logic          out_ready,
    input  pkf_pkg::est_t out_data
);

    // a stalled result holds
    `PKF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // one request in flight: no second request right behind an accepted one
    `PKF_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready ##1 !in_ready)

    // a new result only appears at the end of a request's work
    `PKF_ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind pose_kalman_filter_six_channel pkf_chk u_pkf_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/pose_kalman_filter_six_channel_tb.sv =====
`timescale 1ns / 100ps

module pose_kalman_filter_six_channel_tb;
    import pkf_pkg::*;

    localparam int NUM_CH = CHANNELS_DEF;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;
    localparam logic [31:0] NOISE_MAX = 32'hFFFF_FFFF;

    typedef enum logic {ROW_POSE, ROW_NOISE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        meas_t       pose;
        bit          typed;
        est_t        want;
        logic [31:0] qf;
        logic [31:0] qr;
        logic [31:0] rf;
        logic [31:0] rr;
    } plan_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    meas_t    in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    est_t     out_data;
    logic     cfg_wr_en = 1'b0;
    cfg_reg_t cfg_index = CFG_Q_FIRST;
    logic [DW-1:0] cfg_data = '0;

    // filter state tracked alongside the block
    logic signed [31:0] est_track [6];
    logic [31:0] var_track [2];
    logic [31:0] q_first_cfg, q_rest_cfg, r_first_cfg, r_rest_cfg;
    logic signed [31:0] last_pose [6];

    est_t est_pending [$];
    plan_row_t directed_plan [$];

    int meas_taken = 0;
    int bad_taken = 0;
    int est_seen = 0;
    int mismatch_count = 0;
    int orphan_count = 0;
    int noise_loads = 0;
    bit steady = 1'b0;
    bit hold_out = 1'b0;
    int phase_items [7] = '{260, 240, 200, 60, 240, 200, 200};

    pose_kalman_filter_six_channel #(.CHANNELS(NUM_CH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // fixed point helpers
    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? NOISE_MAX : s[31:0];
    endfunction

    function automatic logic [16:0] kalman_gain(input logic [31:0] pp, input logic [31:0] r);
        logic [63:0] den;
        den = 64'(pp) + 64'(r);
        if (den == 64'd0)
            return '0;
        return 17'((64'(pp) << 16) / den);
    endfunction

    function automatic logic [31:0] shrink_var(input logic [31:0] pp, input logic [16:0] k);
        return 32'((64'(pp) * (64'(ONE_Q16) - 64'(k))) >> 16);
    endfunction

    // move estimate toward measurement by gain, truncating the correction toward zero
    function automatic logic signed [31:0] pull_toward(input logic signed [31:0] x,
                                                        input logic signed [31:0] z,
                                                        input logic [16:0] k);
        longint d;
        longint c;
        longint n;
        d = longint'(z) - longint'(x);
        c = ((d < 0 ? -d : d) * longint'(k)) >> 16;
        n = (d < 0) ? longint'(x) - c : longint'(x) + c;
        if (n > 64'sd2147483647)
            n = 64'sd2147483647;
        if (n < -64'sd2147483648)
            n = -64'sd2147483648;
        return n[31:0];
    endfunction

    // one predict and update step, returns the result the block should give
    function automatic est_t advance_filter(input meas_t m);
        logic signed [31:0] z [6];
        logic [31:0] pp_first, pp_rest;
        logic [16:0] k_first, k_rest;
        est_t r;
        z[0] = m.meas_x;
        z[1] = m.meas_y;
        z[2] = m.meas_z;
        z[3] = m.meas_roll;
        z[4] = m.meas_pitch;
        z[5] = m.meas_yaw;
        if (!m.meas_bad)
        begin
            pp_first = sat_sum(var_track[0], q_first_cfg);
            pp_rest = sat_sum(var_track[1], q_rest_cfg);
            k_first = kalman_gain(pp_first, r_first_cfg);
            k_rest = kalman_gain(pp_rest, r_rest_cfg);
            for (int i = 0; i < 6; i++)
                if (i < NUM_CH)
                    est_track[i] = pull_toward(est_track[i], z[i], i == 0 ? k_first : k_rest);
            var_track[0] = shrink_var(pp_first, k_first);
            if (NUM_CH > 1)
                var_track[1] = shrink_var(pp_rest, k_rest);
        end
        r.est_x = est_track[0];
        r.est_y = est_track[1];
        r.est_z = est_track[2];
        r.est_roll = est_track[3];
        r.est_pitch = est_track[4];
        r.est_yaw = est_track[5];
        r.var_first_out = var_track[0];
        r.var_rest_out = var_track[1];
        r.skipped = m.meas_bad;
        return r;
    endfunction

    // directed plan rows
    function automatic plan_row_t pose_row(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z, input logic [31:0] ro,
                                           input logic [31:0] pi, input logic [31:0] ya,
                                           input logic bad);
        plan_row_t row;
        row.kind = ROW_POSE;
        row.pose = {x, y, z, ro, pi, ya, bad};
        row.typed = 1'b0;
        row.want = '0;
        row.qf = '0;
        row.qr = '0;
        row.rf = '0;
        row.rr = '0;
        return row;
    endfunction

    function automatic plan_row_t known_row(input plan_row_t row, input est_t want);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic est_t est_of(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic [31:0] ro,
                                    input logic [31:0] pi, input logic [31:0] ya,
                                    input logic [31:0] vf, input logic [31:0] vr,
                                    input logic skip);
        return {x, y, z, ro, pi, ya, vf, vr, skip};
    endfunction

    function automatic plan_row_t noise_row(input logic [31:0] qf, input logic [31:0] qr,
                                            input logic [31:0] rf, input logic [31:0] rr);
        plan_row_t row;
        row = pose_row('0, '0, '0, '0, '0, '0, 1'b0);
        row.kind = ROW_NOISE;
        row.qf = qf;
        row.qr = qr;
        row.rf = rf;
        row.rr = rr;
        return row;
    endfunction

    // random pose: mostly tracking a moving target, some full range and extremes
    function automatic meas_t draw_meas();
        logic signed [31:0] v [6];
        int pick;
        meas_t m;
        for (int i = 0; i < 6; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                case ($urandom_range(4))
                    0: v[i] = POS_MAX;
                    1: v[i] = NEG_MAX;
                    2: v[i] = 32'sd0;
                    3: v[i] = -32'sd1;
                    default: v[i] = 32'sd65536;
                endcase
            end
            else if (pick < 35)
                v[i] = $urandom;
            else
                v[i] = last_pose[i] + (int'($urandom_range(0, 131072)) - 65536);
        end
        m = {v[0], v[1], v[2], v[3], v[4], v[5], 1'b0};
        m.meas_bad = ($urandom_range(99) < 10);
        if (!m.meas_bad)
            for (int i = 0; i < 6; i++)
                last_pose[i] = v[i];
        return m;
    endfunction

    // offer one request and hold it until taken
    task automatic offer_meas(input meas_t m, input bit typed, input est_t want);
        est_t predicted;
        in_valid <= 1'b1;
        in_data <= m;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = advance_filter(m);
        est_pending.push_back(typed ? want : predicted);
        meas_taken++;
        if (m.meas_bad)
            bad_taken++;
    endtask

    // random gap before the next request
    task automatic maybe_pause();
        if (!steady && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding estimate
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (est_pending.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // write all four noise registers while idle
    task automatic load_noise(input logic [31:0] qf, input logic [31:0] qr,
                              input logic [31:0] rf, input logic [31:0] rr);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_Q_FIRST;
        cfg_data <= qf;
        @(posedge clk);
        cfg_index <= CFG_Q_REST;
        cfg_data <= qr;
        @(posedge clk);
        cfg_index <= CFG_R_FIRST;
        cfg_data <= rf;
        @(posedge clk);
        cfg_index <= CFG_R_REST;
        cfg_data <= rr;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        q_first_cfg = qf;
        q_rest_cfg = qr;
        r_first_cfg = rf;
        r_rest_cfg = rr;
        noise_loads++;
    endtask

    // receiver with random stalls
    always @(posedge clk)
        out_ready <= !hold_out && (steady || $urandom_range(99) >= 32);

    // one long receiver stall while requests keep coming
    initial
    begin : long_stall
        wait (meas_taken >= 400);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (600) @(posedge clk);
        hold_out <= 1'b0;
    end

    function automatic bit field_off(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (want === got)
            return 1'b0;
        if (mismatch_count < 10)
            $display("mismatch in %s, estimate %0d: expected %h, got %h",
                     name, est_seen, want, got);
        return 1'b1;
    endfunction

    // compare each estimate with the oldest prediction
    always @(posedge clk)
    begin : est_check
        est_t want;
        bit off;
        if (rst_n && out_valid && out_ready)
        begin
            if (est_pending.size() == 0)
            begin
                if (orphan_count < 10)
                    $display("estimate %0d arrived with no request outstanding", est_seen);
                orphan_count++;
            end
            else
            begin
                want = est_pending.pop_front();
                off = field_off("est_x", want.est_x, out_data.est_x)
                    | field_off("est_y", want.est_y, out_data.est_y)
                    | field_off("est_z", want.est_z, out_data.est_z)
                    | field_off("est_roll", want.est_roll, out_data.est_roll)
                    | field_off("est_pitch", want.est_pitch, out_data.est_pitch)
                    | field_off("est_yaw", want.est_yaw, out_data.est_yaw)
                    | field_off("var_first_out", want.var_first_out, out_data.var_first_out)
                    | field_off("var_rest_out", want.var_rest_out, out_data.var_rest_out)
                    | field_off("skipped", want.skipped, out_data.skipped);
                if (off)
                    mismatch_count++;
            end
            est_seen++;
        end
    end

    // overall time limit
    initial
    begin : watchdog
        #4_000_000;
        $display("timeout with %0d estimates outstanding", est_pending.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        for (int i = 0; i < 6; i++)
        begin
            est_track[i] = '0;
            last_pose[i] = '0;
        end
        var_track[0] = VAR_RST;
        var_track[1] = VAR_RST;
        q_first_cfg = Q_FIRST_RST;
        q_rest_cfg = Q_REST_RST;
        r_first_cfg = R_FIRST_RST;
        r_rest_cfg = R_REST_RST;

        // bad request right after reset returns the reset state
        directed_plan.push_back(known_row(
            pose_row(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444,
                     32'h5555_5555, 32'h6666_6666, 1'b1),
            est_of('0, '0, '0, '0, '0, '0, VAR_RST, VAR_RST, 1'b1)));
        // default noise
        directed_plan.push_back(pose_row(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                                         32'h0003_243F, 32'hFFFC_DBC1, 32'h0000_0001, 1'b0));
        directed_plan.push_back(pose_row(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                                         POS_MAX, 1'b0));
        directed_plan.push_back(pose_row(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX,
                                         NEG_MAX, 1'b0));
        directed_plan.push_back(pose_row(32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0, POS_MAX,
                                         NEG_MAX, 32'hAAAA_AAAA, 1'b1));
        // huge process noise, no measurement noise: full gain, estimate jumps to measurement
        directed_plan.push_back(noise_row(NOISE_MAX, NOISE_MAX, '0, '0));
        directed_plan.push_back(known_row(
            pose_row(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0),
            est_of(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, '0, '0, 1'b0)));
        directed_plan.push_back(known_row(
            pose_row(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 1'b0),
            est_of(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, '0, '0, 1'b0)));
        directed_plan.push_back(known_row(
            pose_row('0, 32'hFFFF_FFFF, 32'h1, POS_MAX, NEG_MAX, 32'h5555_5555, 1'b0),
            est_of('0, 32'hFFFF_FFFF, 32'h1, POS_MAX, NEG_MAX, 32'h5555_5555, '0, '0, 1'b0)));
        directed_plan.push_back(known_row(
            pose_row(32'h1234_5678, 32'h9ABC_DEF0, POS_MAX, NEG_MAX, '0, '0, 1'b1),
            est_of('0, 32'hFFFF_FFFF, 32'h1, POS_MAX, NEG_MAX, 32'h5555_5555, '0, '0, 1'b1)));
        // zero innovation variance: gain is zero, estimate held
        directed_plan.push_back(noise_row('0, '0, '0, '0));
        directed_plan.push_back(known_row(
            pose_row(32'h1234_5678, 32'h9ABC_DEF0, NEG_MAX, '0, POS_MAX, 32'hAAAA_AAAA, 1'b0),
            est_of('0, 32'hFFFF_FFFF, 32'h1, POS_MAX, NEG_MAX, 32'h5555_5555, '0, '0, 1'b0)));
        // huge measurement noise with zero variance: still no correction
        directed_plan.push_back(noise_row('0, '0, NOISE_MAX, NOISE_MAX));
        directed_plan.push_back(known_row(
            pose_row(NEG_MAX, POS_MAX, NEG_MAX, '0, POS_MAX, '0, 1'b0),
            est_of('0, 32'hFFFF_FFFF, 32'h1, POS_MAX, NEG_MAX, 32'h5555_5555, '0, '0, 1'b0)));
        // unit noise, half gain
        directed_plan.push_back(noise_row(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                          32'h0001_0000));
        directed_plan.push_back(pose_row(32'h0000_0003, 32'h0000_0001, 32'hFFFF_FFFD,
                                         NEG_MAX, POS_MAX, 32'hFFFF_FFFF, 1'b0));
        directed_plan.push_back(pose_row(32'hFFFF_FFFB, 32'h0007_0000, 32'h0000_0002,
                                         32'hC000_0000, 32'h4000_0000, 32'h0000_0003, 1'b0));
        directed_plan.push_back(pose_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
        // every noise register at its maximum, saturated prediction
        directed_plan.push_back(noise_row(NOISE_MAX, NOISE_MAX, NOISE_MAX, NOISE_MAX));
        directed_plan.push_back(pose_row(POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, POS_MAX,
                                         NEG_MAX, 1'b0));
        directed_plan.push_back(pose_row(NEG_MAX, POS_MAX, 32'h0, 32'hFFFF_FFFF, 32'h1,
                                         32'h8000_0001, 1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_NOISE)
                load_noise(directed_plan[i].qf, directed_plan[i].qr,
                           directed_plan[i].rf, directed_plan[i].rr);
            else
            begin
                maybe_pause();
                offer_meas(directed_plan[i].pose, directed_plan[i].typed,
                           directed_plan[i].want);
            end
        end

        // random part, one noise setting per phase
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: load_noise(Q_FIRST_RST, Q_REST_RST, R_FIRST_RST, R_REST_RST);
                1: load_noise($urandom_range(0, 262144), $urandom_range(0, 262144),
                              $urandom_range(0, 262144), $urandom_range(0, 262144));
                2: load_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX, NOISE_MAX);
                3: load_noise('0, '0, '0, '0);
                4: load_noise($urandom, $urandom, $urandom, $urandom);
                5: load_noise($urandom_range(0, 1000), $urandom_range(0, 1000),
                              $urandom_range(32'h1000_0000, NOISE_MAX),
                              $urandom_range(32'h1000_0000, NOISE_MAX));
                default: load_noise($urandom_range(0, 6554), $urandom_range(0, 655),
                                    $urandom_range(0, 13107), $urandom_range(0, 655));
            endcase
            steady <= (ph == 5);
            for (int n = 0; n < phase_items[ph]; n++)
            begin
                if (ph == 4 && n == 120)
                    settle();
                maybe_pause();
                offer_meas(draw_meas(), 1'b0, '0);
            end
        end

        // drain
        in_valid <= 1'b0;
        while (est_pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("run covered %0d pose requests (%0d flagged bad) under %0d noise settings",
                 meas_taken, bad_taken, noise_loads);
        $display("%0d estimates compared, %0d mismatched, %0d unexpected, %0d missing",
                 est_seen, mismatch_count, orphan_count, est_pending.size());
        if (mismatch_count == 0 && orphan_count == 0 && est_pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
